>>> rtl/ffa_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

    // Header width in bytes; the next header follows the payload directly.
    localparam int HDR_BYTES = 8;

    // Width of a chain position; holds any position that a walk can reach.
    localparam int POS_W = 18;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    // One block header word as stored in the header memory.
    typedef struct packed {
        logic        valid;
        logic        used;
        logic [15:0] size;
    } t_hdr;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_CHK,
        S_SPLIT,
        S_MARK,
        S_FREE_CHK
    } t_state;

endpackage

>>> rtl/ffa_hdr_mem.sv
// Header memory: one write port, one read port with registered read data.
module ffa_hdr_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output ffa_pkg::t_hdr      o_rd_data,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  ffa_pkg::t_hdr      i_wr_data
);

    ffa_pkg::t_hdr r_mem [DEPTH];
    ffa_pkg::t_hdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: request sequencer around the header memory.
//
//  channel   direction  handshake            word fields
//  request   in         start & !busy        i_req_type, i_alloc_size, i_free_offset
//  result    out        o_done (one cycle)   o_payload_offset, o_status
//
// Allocate: the walk reads one header per cycle from the header memory port,
//   in S_ALLOC_CHK; a block taken whole is then marked in S_MARK, a split
//   block gets its remainder header in S_SPLIT before S_MARK, and a no-fit
//   or a broken chain ends the walk.
// A free keeps busy high through S_FREE_CHK (read, then write back), or returns
//   its bad-free word at once without going busy when the offset is out of range.
// Each result word appears on o_done for one cycle, with busy already low;
//   a new request may be taken in that same cycle. The receiver cannot stall.
// Reset: after i_rst_n releases, a clearing pass writes every header entry,
//   with busy high; entry zero receives the single free block.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [15:0] i_alloc_size,
    input  logic [15:0] i_free_offset,
    output logic        o_done,
    output logic [15:0] o_payload_offset,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int PW = ffa_pkg::POS_W;
    localparam logic [PW-1:0] HEAP_END  = PW'(HEAP_BYTES);
    localparam logic [PW-1:0] HDR_POS   = PW'(ffa_pkg::HDR_BYTES);
    localparam logic [15:0]   HDR_16    = 16'(ffa_pkg::HDR_BYTES);
    localparam logic [16:0]   HDR_17    = 17'(ffa_pkg::HDR_BYTES);
    localparam logic [AW-1:0] CLR_LAST  = AW'(HEAP_BYTES - 1);
    localparam logic [15:0]   INIT_SIZE = 16'(HEAP_BYTES - ffa_pkg::HDR_BYTES);

    // Control registers.
    ffa_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_done, n_done;

    // Payload registers.
    logic [PW-1:0]    r_pos, n_pos;
    logic [15:0]      r_size, n_size;
    logic [15:0]      r_keep, n_keep;
    logic [15:0]      r_rest_size, n_rest_size;
    logic [AW-1:0]    r_at, n_at;
    logic [15:0]      r_off, n_off;
    ffa_pkg::t_status r_status, n_status;

    // Header memory port.
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    ffa_pkg::t_hdr    mem_rd_data;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    ffa_pkg::t_hdr    mem_wr_data;

    // Datapath helpers.
    ffa_pkg::t_hdr    hdr;
    logic             accept;
    logic             fits;
    logic             split;
    logic [PW-1:0]    nxt_pos;
    logic             nxt_ok;
    logic [PW-1:0]    rest_pos;
    logic             rest_in;
    logic [PW-1:0]    pay_pos;
    logic [PW-1:0]    free_at;
    logic             free_bad;

    ffa_hdr_mem #(
        .DEPTH (HEAP_BYTES),
        .AW    (AW)
    ) u_hdr_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    assign hdr    = mem_rd_data;
    assign busy   = (r_state != ffa_pkg::S_IDLE);
    assign accept = start && !busy;

    // A block is taken when it is free and holds the request; split it only when
    // more than the request plus one header remains.
    assign fits     = !hdr.used && (hdr.size >= r_size);
    assign split    = ({1'b0, hdr.size} > ({1'b0, r_size} + HDR_17));
    // Next header in the chain, and whether a whole header still fits in the heap.
    assign nxt_pos  = r_pos + HDR_POS + PW'(hdr.size);
    assign nxt_ok   = (nxt_pos + HDR_POS) <= HEAP_END;
    // Remainder header behind a split block; drop it if it falls past the heap.
    assign rest_pos = r_pos + HDR_POS + PW'(r_size);
    assign rest_in  = rest_pos < HEAP_END;
    assign pay_pos  = r_pos + HDR_POS;
    // A free needs its header one header below the offset, inside the heap.
    assign free_at  = PW'(i_free_offset) - HDR_POS;
    assign free_bad = (i_free_offset < HDR_16) || (free_at >= HEAP_END);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffa_pkg::S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end
            ffa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req_type == ffa_pkg::REQ_ALLOC) begin
                        n_state = ffa_pkg::S_ALLOC_CHK;
                    end else if (!free_bad) begin
                        n_state = ffa_pkg::S_FREE_CHK;
                    end
                end
            end
            ffa_pkg::S_ALLOC_CHK: begin
                if (!hdr.valid) begin
                    n_state = ffa_pkg::S_IDLE;
                end else if (fits) begin
                    n_state = split ? ffa_pkg::S_SPLIT : ffa_pkg::S_MARK;
                end else if (!nxt_ok) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end
            ffa_pkg::S_SPLIT: begin
                n_state = ffa_pkg::S_MARK;
            end
            ffa_pkg::S_MARK: begin
                n_state = ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_FREE_CHK: begin
                n_state = ffa_pkg::S_IDLE;
            end
            default: begin
                n_state = ffa_pkg::S_CLEAR;
            end
        endcase
    end

    // Memory controls, result word and datapath register updates.
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        n_clr       = r_clr;
        n_done      = 1'b0;
        n_off       = r_off;
        n_status    = r_status;
        n_pos       = r_pos;
        n_size      = r_size;
        n_keep      = r_keep;
        n_rest_size = r_rest_size;
        n_at        = r_at;
        unique case (r_state)
            ffa_pkg::S_CLEAR: begin
                // Sweep the memory; entry zero gets the one free block.
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
                if (r_clr == '0) begin
                    mem_wr_data = '{valid: 1'b1, used: 1'b0, size: INIT_SIZE};
                end
                n_clr = r_clr + 1'b1;
            end
            ffa_pkg::S_IDLE: begin
                n_pos = '0;
                if (accept) begin
                    n_size = i_alloc_size;
                    if (i_req_type == ffa_pkg::REQ_ALLOC) begin
                        // Start the walk at the first header.
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                    end else if (free_bad) begin
                        n_done   = 1'b1;
                        n_off    = '0;
                        n_status = ffa_pkg::ST_BADFREE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = free_at[AW-1:0];
                        n_at        = free_at[AW-1:0];
                    end
                end
            end
            ffa_pkg::S_ALLOC_CHK: begin
                if (!hdr.valid) begin
                    // Broken chain ends the walk.
                    n_done   = 1'b1;
                    n_off    = '0;
                    n_status = ffa_pkg::ST_NOFIT;
                end else if (fits) begin
                    n_keep      = split ? r_size : hdr.size;
                    n_rest_size = hdr.size - r_size - HDR_16;
                end else if (nxt_ok) begin
                    // Advance to the next header, one read per cycle.
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = nxt_pos[AW-1:0];
                    n_pos       = nxt_pos;
                end else begin
                    n_done   = 1'b1;
                    n_off    = '0;
                    n_status = ffa_pkg::ST_NOFIT;
                end
            end
            ffa_pkg::S_SPLIT: begin
                mem_wr_en   = rest_in;
                mem_wr_addr = rest_pos[AW-1:0];
                mem_wr_data = '{valid: 1'b1, used: 1'b0, size: r_rest_size};
            end
            ffa_pkg::S_MARK: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_pos[AW-1:0];
                mem_wr_data = '{valid: 1'b1, used: 1'b1, size: r_keep};
                n_done      = 1'b1;
                n_off       = pay_pos[15:0];
                n_status    = ffa_pkg::ST_OK;
            end
            ffa_pkg::S_FREE_CHK: begin
                n_done = 1'b1;
                n_off  = '0;
                if (hdr.valid) begin
                    // Clear the used mark, keep the size.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_at;
                    mem_wr_data = '{valid: 1'b1, used: 1'b0, size: hdr.size};
                    n_status    = ffa_pkg::ST_OK;
                end else begin
                    n_status = ffa_pkg::ST_BADFREE;
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_size      <= n_size;
        r_keep      <= n_keep;
        r_rest_size <= n_rest_size;
        r_at        <= n_at;
        r_off       <= n_off;
        r_status    <= n_status;
    end

    assign o_done           = r_done;
    assign o_payload_offset = r_off;
    assign o_status         = r_status;

    // A result word follows a cycle of work or an accepted request.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept || (r_state != ffa_pkg::S_IDLE)))
        else $error("result word without a request in progress");

    // Failed requests carry a zero offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ffa_pkg::ST_OK)) |-> (o_payload_offset == '0))
        else $error("failed request returned a nonzero offset");

    // Header writes happen only in the write states.
    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> ((r_state == ffa_pkg::S_CLEAR) || (r_state == ffa_pkg::S_SPLIT) ||
                       (r_state == ffa_pkg::S_MARK) || (r_state == ffa_pkg::S_FREE_CHK)))
        else $error("header write outside a write state");

    // Read and write never share a cycle, so no forwarding is needed.
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("header read and write in the same cycle");

    // A split always ends by marking the taken block.
    a_split_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_SPLIT) |=> (r_state == ffa_pkg::S_MARK))
        else $error("split not followed by the used-mark write");

endmodule
